>>> sv/ihex_pkg.sv
// Shared types, codes and helpers for the hex record parser.
package ihex_pkg;

  typedef enum logic [1:0] {
    MODE_CHAR    = 2'd0,
    MODE_END     = 2'd1,
    MODE_READ    = 2'd2,
    MODE_RESTART = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_COUNT,
    PH_ADDR_HI,
    PH_ADDR_LO,
    PH_TYPE,
    PH_DATA,
    PH_CHECK
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_HEX      = 3'd1,
    ERR_CHECKSUM = 3'd2,
    ERR_TYPE     = 3'd3,
    ERR_CHAR     = 3'd4,
    ERR_EARLY    = 3'd5
  } err_t;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] REC_DATA   = 8'h00;
  localparam logic [7:0] REC_EOF    = 8'h01;

  localparam int STORE_DEPTH = 256;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  // Output queue: deep enough to keep one beat per cycle behind the result stage while out_ch stays ready.
  localparam int OFIFO_DEPTH = 3;
  localparam int OFIFO_PW    = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CW    = $clog2(OFIFO_DEPTH + 1);

  typedef struct packed {
    logic                data_valid;
    logic [7:0]          data_byte;
    logic [15:0]         data_address;
    logic                last_of_record;
    logic                record_ready;
    logic                record_accepted;
    logic                eof_seen;
    logic [2:0]          error_code;
    logic [15:0]         end_address;
  } result_t;

  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic                re;
    logic [STORE_AW-1:0] raddr;
  } store_req_t;

  // {valid, value} of an ASCII hex digit, either case.
  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

>>> sv/ihex_in_if.sv
// Input channel: one text character or command per beat.
interface ihex_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] char_code;

  modport source(output valid, output mode, output char_code, input ready);
  modport sink(input valid, input mode, input char_code, output ready);
endinterface

>>> sv/ihex_out_if.sv
// Result channel: one status/data result per beat.
interface ihex_out_if;
  logic        valid;
  logic        ready;
  logic        data_valid;
  logic [7:0]  data_byte;
  logic [15:0] data_address;
  logic        last_of_record;
  logic        record_ready;
  logic        record_accepted;
  logic        eof_seen;
  logic [2:0]  error_code;
  logic [15:0] end_address;

  modport source(output valid, output data_valid, output data_byte, output data_address,
                 output last_of_record, output record_ready, output record_accepted,
                 output eof_seen, output error_code, output end_address, input ready);
  modport sink(input valid, input data_valid, input data_byte, input data_address,
               input last_of_record, input record_ready, input record_accepted,
               input eof_seen, input error_code, input end_address, output ready);
endinterface

>>> sv/ihex_store.sv
// 256 x 8 record store, one write and one registered read port.
module ihex_store (
  input  logic                clk,
  input  ihex_pkg::store_req_t req,
  output logic [7:0]          rdata
);
  import ihex_pkg::*;

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

>>> sv/ihex_parse_core.sv
// Record parser state, checksum, store control and result stage.
module ihex_parse_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [1:0]           mode,
  input  logic [7:0]           char_code,
  output ihex_pkg::store_req_t store_req,
  output logic                 res_v,
  output ihex_pkg::result_t    res
);
  import ihex_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic [3:0]           hi_r, hi_nxt;
  logic                 pend_r, pend_nxt;
  logic [7:0]           count_r, count_nxt;
  logic [7:0]           rtype_r, rtype_nxt;
  logic [7:0]           sum_r, sum_nxt;
  logic [7:0]           left_r, left_nxt;
  logic [STORE_AW-1:0]  widx_r, widx_nxt;
  logic [8:0]           unread_r, unread_nxt;
  logic [STORE_AW-1:0]  ridx_r, ridx_nxt;
  logic [15:0]          addr_r, addr_nxt;
  logic                 eof_r, eof_nxt;
  err_t                 err_r, err_nxt;
  logic [15:0]          max_r, max_nxt;
  logic                 res_v_r;
  result_t              res_r, res_nxt;

  logic [4:0]  hx;
  logic [7:0]  b;
  logic [15:0] end_addr;
  logic        acc;
  logic        dv;
  logic        last;
  logic [15:0] dv_addr;

  assign hx       = hex_nibble(char_code);
  assign b        = {hi_r, hx[3:0]};
  assign end_addr = addr_r + {8'd0, count_r};

  always_comb begin
    phase_nxt  = phase_r;
    hi_nxt     = hi_r;
    pend_nxt   = pend_r;
    count_nxt  = count_r;
    rtype_nxt  = rtype_r;
    sum_nxt    = sum_r;
    left_nxt   = left_r;
    widx_nxt   = widx_r;
    unread_nxt = unread_r;
    ridx_nxt   = ridx_r;
    addr_nxt   = addr_r;
    eof_nxt    = eof_r;
    err_nxt    = err_r;
    max_nxt    = max_r;
    acc        = 1'b0;
    dv         = 1'b0;
    last       = 1'b0;
    dv_addr    = 16'd0;
    store_req  = '0;
    store_req.waddr = widx_r;
    store_req.wdata = b;
    store_req.raddr = ridx_r;

    if (fire) begin
      if (mode_t'(mode) == MODE_RESTART) begin
        phase_nxt  = PH_IDLE;
        hi_nxt     = 4'd0;
        pend_nxt   = 1'b0;
        count_nxt  = 8'd0;
        rtype_nxt  = 8'd0;
        sum_nxt    = 8'd0;
        left_nxt   = 8'd0;
        widx_nxt   = '0;
        unread_nxt = 9'd0;
        ridx_nxt   = '0;
        addr_nxt   = 16'd0;
        eof_nxt    = 1'b0;
        err_nxt    = ERR_NONE;
        max_nxt    = 16'd0;
      end else if (err_r != ERR_NONE) begin
        // sticky: hold everything
      end else if (mode_t'(mode) == MODE_CHAR) begin
        if (!eof_r) begin
          if (phase_r == PH_IDLE) begin
            if (char_code == CHAR_COLON) begin
              unread_nxt = 9'd0;
              ridx_nxt   = '0;
              sum_nxt    = 8'd0;
              pend_nxt   = 1'b0;
              hi_nxt     = 4'd0;
              phase_nxt  = PH_COUNT;
            end else if (!(char_code == CHAR_SPACE || char_code inside {[8'd9:8'd13]})) begin
              err_nxt = ERR_CHAR;
            end
          end else if (!hx[4]) begin
            err_nxt   = ERR_HEX;
            phase_nxt = PH_IDLE;
          end else if (!pend_r) begin
            hi_nxt   = hx[3:0];
            pend_nxt = 1'b1;
          end else begin
            pend_nxt = 1'b0;
            case (phase_r)
              PH_COUNT: begin
                count_nxt = b;
                sum_nxt   = sum_r + b;
                phase_nxt = PH_ADDR_HI;
              end
              PH_ADDR_HI: begin
                addr_nxt  = {b, 8'd0};
                sum_nxt   = sum_r + b;
                phase_nxt = PH_ADDR_LO;
              end
              PH_ADDR_LO: begin
                addr_nxt  = {addr_r[15:8], addr_r[7:0] | b};
                sum_nxt   = sum_r + b;
                phase_nxt = PH_TYPE;
              end
              PH_TYPE: begin
                rtype_nxt = b;
                sum_nxt   = sum_r + b;
                left_nxt  = count_r;
                widx_nxt  = '0;
                phase_nxt = (count_r != 8'd0) ? PH_DATA : PH_CHECK;
              end
              PH_DATA: begin
                store_req.we = 1'b1;
                widx_nxt     = widx_r + 1'b1;
                sum_nxt      = sum_r + b;
                left_nxt     = left_r - 8'd1;
                if (left_r == 8'd1) begin
                  phase_nxt = PH_CHECK;
                end
              end
              PH_CHECK: begin
                phase_nxt = PH_IDLE;
                if (8'(8'd0 - sum_r) != b) begin
                  err_nxt = ERR_CHECKSUM;
                end else if (rtype_r == REC_EOF) begin
                  eof_nxt = 1'b1;
                end else if (rtype_r != REC_DATA) begin
                  err_nxt = ERR_TYPE;
                end else begin
                  if (end_addr > max_r) begin
                    max_nxt = end_addr;
                  end
                  unread_nxt = {1'b0, count_r};
                  ridx_nxt   = '0;
                  acc        = 1'b1;
                end
              end
              default: begin
                phase_nxt = PH_IDLE;
              end
            endcase
          end
        end
      end else if (mode_t'(mode) == MODE_END) begin
        if (!eof_r) begin
          err_nxt = ERR_EARLY;
        end
      end else if (unread_r != 9'd0) begin
        // read one stored byte; data arrives from the store next cycle
        dv           = 1'b1;
        store_req.re = 1'b1;
        dv_addr      = addr_r;
        last         = (unread_r == 9'd1);
        ridx_nxt     = ridx_r + 1'b1;
        addr_nxt     = addr_r + 16'd1;
        unread_nxt   = unread_r - 9'd1;
      end
    end

    res_nxt.data_valid      = dv;
    res_nxt.data_byte       = 8'd0;
    res_nxt.data_address    = dv_addr;
    res_nxt.last_of_record  = last;
    res_nxt.record_ready    = (unread_nxt != 9'd0);
    res_nxt.record_accepted = acc;
    res_nxt.eof_seen        = eof_nxt;
    res_nxt.error_code      = err_nxt;
    res_nxt.end_address     = max_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      hi_r     <= 4'd0;
      pend_r   <= 1'b0;
      count_r  <= 8'd0;
      rtype_r  <= 8'd0;
      sum_r    <= 8'd0;
      left_r   <= 8'd0;
      widx_r   <= '0;
      unread_r <= 9'd0;
      ridx_r   <= '0;
      addr_r   <= 16'd0;
      eof_r    <= 1'b0;
      err_r    <= ERR_NONE;
      max_r    <= 16'd0;
      res_v_r  <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      hi_r     <= hi_nxt;
      pend_r   <= pend_nxt;
      count_r  <= count_nxt;
      rtype_r  <= rtype_nxt;
      sum_r    <= sum_nxt;
      left_r   <= left_nxt;
      widx_r   <= widx_nxt;
      unread_r <= unread_nxt;
      ridx_r   <= ridx_nxt;
      addr_r   <= addr_nxt;
      eof_r    <= eof_nxt;
      err_r    <= err_nxt;
      max_r    <= max_nxt;
      res_v_r  <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign res_v = res_v_r;
  assign res   = res_r;

  // store is never written and read in the same cycle
  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    !(store_req.we && store_req.re))
    else $error("store write and read in the same cycle");

  // an error holds until a restart beat
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ERR_NONE && !(fire && mode_t'(mode) == MODE_RESTART)) |=> $stable(err_r))
    else $error("sticky error changed without restart");
endmodule

>>> sv/ihex_out_fifo.sv
// Small result queue between the result stage and the output channel.
module ihex_out_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  ihex_pkg::result_t          push_item,
  input  logic                       pop,
  output logic                       not_empty,
  output ihex_pkg::result_t          head,
  output logic [ihex_pkg::OFIFO_CW-1:0] count
);
  import ihex_pkg::*;

  result_t             q_r [OFIFO_DEPTH];
  logic [OFIFO_PW-1:0] wp_r, wp_nxt;
  logic [OFIFO_PW-1:0] rp_r, rp_nxt;
  logic [OFIFO_CW-1:0] cnt_r, cnt_nxt;
  logic                do_pop;

  assign do_pop = pop && (cnt_r != '0);

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == OFIFO_PW'(OFIFO_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == OFIFO_PW'(OFIFO_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_item;
    end
  end

  assign not_empty = (cnt_r != '0);
  assign head      = q_r[rp_r];
  assign count     = cnt_r;

  // upstream flow control must never overfill the queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !do_pop && cnt_r == OFIFO_CW'(OFIFO_DEPTH)))
    else $error("result queue overflow");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= OFIFO_CW'(OFIFO_DEPTH))
    else $error("result queue count out of range");
endmodule

>>> sv/intel_hex_record_parser.sv
// Top level of the hex record parser: character parser, record store, result queue.
//
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   mode[1:0], char_code[7:0]
//  out_ch   out  valid/ready   data_valid, data_byte, data_address, last_of_record,
//                              record_ready, record_accepted, eof_seen,
//                              error_code[2:0], end_address
//
// Cycles: one beat in per cycle while in_ch.ready holds, one result beat per input beat, in order.
// Path from an input beat to out_ch: the parser state, the result stage and the
// store read register update at the input beat, and the result queue entry is
// written in the cycle after.
// Reset (rst_n low, synchronous) clears parser state and the queue; the store is
// not cleared and needs no clearing pass, since only fully written records are read.
// Stalls: in_ch.ready drops once the queue plus the result stage hold three beats.

module intel_hex_record_parser (
  input  logic          clk,
  input  logic          rst_n,
  ihex_in_if.sink       in_ch,
  ihex_out_if.source    out_ch
);
  import ihex_pkg::*;

  logic                in_fire;
  store_req_t          store_req;
  logic [7:0]          store_rdata;
  logic                res_v;
  result_t             res;
  result_t             res_full;
  result_t             head;
  logic                head_v;
  logic [OFIFO_CW-1:0] q_count;
  logic [OFIFO_CW:0]   in_flight;

  // Beats held in the result stage plus the queue; accept only when one more fits.
  assign in_flight   = {1'b0, q_count} + {{OFIFO_CW{1'b0}}, res_v};
  assign in_ch.ready = (in_flight < (OFIFO_CW + 1)'(OFIFO_DEPTH));
  assign in_fire     = in_ch.valid && in_ch.ready;

  ihex_parse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .mode      (in_ch.mode),
    .char_code (in_ch.char_code),
    .store_req (store_req),
    .res_v     (res_v),
    .res       (res)
  );

  ihex_store u_store (
    .clk   (clk),
    .req   (store_req),
    .rdata (store_rdata)
  );

  // Merge the registered store read into the result; byte reads as zero on non-read beats.
  always_comb begin
    res_full           = res;
    res_full.data_byte = res.data_valid ? store_rdata : 8'd0;
  end

  ihex_out_fifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_v),
    .push_item (res_full),
    .pop       (out_ch.ready),
    .not_empty (head_v),
    .head      (head),
    .count     (q_count)
  );

  assign out_ch.valid           = head_v;
  assign out_ch.data_valid      = head.data_valid;
  assign out_ch.data_byte       = head.data_byte;
  assign out_ch.data_address    = head.data_address;
  assign out_ch.last_of_record  = head.last_of_record;
  assign out_ch.record_ready    = head.record_ready;
  assign out_ch.record_accepted = head.record_accepted;
  assign out_ch.eof_seen        = head.eof_seen;
  assign out_ch.error_code      = head.error_code;
  assign out_ch.end_address     = head.end_address;
endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the hex record parser: directed table, random records.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ihex_pkg::*;

  // Roughly how many random beats follow the directed table.
  localparam int RANDOM_ITEMS = 1350;
  // Cycles with no beat on either channel before the run is declared hung.
  localparam int IDLE_LIMIT   = 2000;
  // Quiet cycles after the last expected result, to catch stray extra beats.
  localparam int DRAIN_CYCLES = 8;

  // One input beat. When fixed is set, the result is known up front:
  // all fields zero except error_code, which takes err.
  typedef struct packed {
    mode_t      m;
    logic [7:0] c;
    logic       fixed;
    err_t       err;
  } beat_t;

  // Directed part. Opens with the simple status cases, then a zero-count data
  // record at the top of the address space in mixed case, then a colon inside
  // a record.
  localparam beat_t DIRECTED [26] = '{
    '{MODE_READ,    8'h00,      1'b1, ERR_NONE},   // read with nothing unread
    '{MODE_END,     8'hFF,      1'b1, ERR_EARLY},  // input ends before end-of-file
    '{MODE_END,     8'h00,      1'b1, ERR_EARLY},  // error holds
    '{MODE_RESTART, 8'h55,      1'b1, ERR_NONE},
    '{MODE_CHAR,    8'h00,      1'b1, ERR_CHAR},   // stray character between records
    '{MODE_RESTART, 8'hAA,      1'b1, ERR_NONE},
    '{MODE_CHAR,    8'h09,      1'b1, ERR_NONE},   // whitespace is skipped
    '{MODE_CHAR,    CHAR_SPACE, 1'b1, ERR_NONE},
    '{MODE_CHAR,    CHAR_COLON, 1'b1, ERR_NONE},
    '{MODE_CHAR,    8'hFF,      1'b1, ERR_HEX},    // non-hex inside a record
    '{MODE_RESTART, 8'h00,      1'b1, ERR_NONE},
    '{MODE_CHAR,    CHAR_COLON, 1'b0, ERR_NONE},   // :00ffFF0002
    '{MODE_CHAR,    "0",        1'b0, ERR_NONE},
    '{MODE_CHAR,    "0",        1'b0, ERR_NONE},
    '{MODE_CHAR,    "f",        1'b0, ERR_NONE},
    '{MODE_CHAR,    "f",        1'b0, ERR_NONE},
    '{MODE_CHAR,    "F",        1'b0, ERR_NONE},
    '{MODE_CHAR,    "F",        1'b0, ERR_NONE},
    '{MODE_CHAR,    "0",        1'b0, ERR_NONE},
    '{MODE_CHAR,    "0",        1'b0, ERR_NONE},
    '{MODE_CHAR,    "0",        1'b0, ERR_NONE},
    '{MODE_CHAR,    "2",        1'b0, ERR_NONE},   // accepted, end address FFFF
    '{MODE_READ,    8'h80,      1'b0, ERR_NONE},   // zero-count record: nothing to read
    '{MODE_CHAR,    CHAR_COLON, 1'b0, ERR_NONE},
    '{MODE_CHAR,    CHAR_COLON, 1'b0, ERR_NONE},   // colon inside a record
    '{MODE_RESTART, 8'h7F,      1'b0, ERR_NONE}
  };

  localparam logic [7:0] WS [6] = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, CHAR_SPACE};

  logic clk;
  logic rst_n;

  ihex_in_if  in_ch();
  ihex_out_if out_ch();

  intel_hex_record_parser uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Whole stimulus, built at time zero; the sender walks it in order.
  beat_t   stim_q[$];
  // Results predicted for accepted beats, oldest first.
  result_t pending_results[$];

  int send_idx   = 0;  // next stimulus entry to present
  int beats_in   = 0;  // accepted input beats
  int beats_out  = 0;  // accepted result beats
  int fail_count = 0;

  // Sender burst/gap shaping.
  int burst_left = 0;
  int gap_left   = 0;

  // Receiver stall pattern.
  int         rx_style = 0;
  int         rx_span  = 0;
  logic [7:0] rx_pat   = 8'h01;

  // ---------------------------------------------------------------------------
  // Predictor state: a shadow copy of the parser.
  // ---------------------------------------------------------------------------
  phase_t      ph;
  logic [3:0]  hi_nib;
  logic        nib_half;
  logic [7:0]  rec_len;
  logic [7:0]  rec_kind;
  logic [7:0]  csum;
  logic [7:0]  data_left;
  logic [7:0]  wr_ptr;
  logic [7:0]  shadow_store [STORE_DEPTH];
  logic [8:0]  unread;
  logic [7:0]  rd_ptr;
  logic [15:0] load_addr;
  logic        eof_hit;
  err_t        err;
  logic [15:0] top_end;

  // Hex digit value of either case, or -1.
  function automatic int digit_val(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    return -1;
  endfunction

  function automatic string show(result_t r);
    return $sformatf("dv=%0d byte=%02h addr=%04h last=%0d rdy=%0d acc=%0d eof=%0d err=%0d end=%04h",
                     r.data_valid, r.data_byte, r.data_address, r.last_of_record,
                     r.record_ready, r.record_accepted, r.eof_seen, r.error_code,
                     r.end_address);
  endfunction

  task automatic clear_parser();
    ph        = PH_IDLE;
    hi_nib    = '0;
    nib_half  = 1'b0;
    rec_len   = '0;
    rec_kind  = '0;
    csum      = '0;
    data_left = '0;
    wr_ptr    = '0;
    foreach (shadow_store[i]) shadow_store[i] = '0;
    unread    = '0;
    rd_ptr    = '0;
    load_addr = '0;
    eof_hit   = 1'b0;
    err       = ERR_NONE;
    top_end   = '0;
  endtask

  // Advance the shadow parser by one beat and return the result it owes.
  task automatic predict_result(input mode_t m, input logic [7:0] c, output result_t r);
    int          v;
    logic [7:0]  b;
    logic [7:0]  want_ck;
    logic [15:0] tail;
    logic        acc;
    r   = '0;
    acc = 1'b0;
    if (m == MODE_RESTART) begin
      clear_parser();
    end else if (err != ERR_NONE) begin
      // sticky: only a restart gets out
    end else if (m == MODE_CHAR) begin
      if (!eof_hit) begin
        if (ph == PH_IDLE) begin
          if (c == CHAR_COLON) begin
            unread   = '0;
            rd_ptr   = '0;
            csum     = '0;
            nib_half = 1'b0;
            hi_nib   = '0;
            ph       = PH_COUNT;
          end else if (c == CHAR_SPACE || (c >= 8'h09 && c <= 8'h0D)) begin
            // whitespace between records
          end else begin
            err = ERR_CHAR;
          end
        end else begin
          v = digit_val(c);
          if (v < 0) begin
            err = ERR_HEX;
            ph  = PH_IDLE;
          end else if (!nib_half) begin
            hi_nib   = v[3:0];
            nib_half = 1'b1;
          end else begin
            nib_half = 1'b0;
            b        = {hi_nib, v[3:0]};
            case (ph)
              PH_COUNT: begin
                rec_len = b;
                csum    = csum + b;
                ph      = PH_ADDR_HI;
              end
              PH_ADDR_HI: begin
                load_addr = {b, 8'h00};
                csum      = csum + b;
                ph        = PH_ADDR_LO;
              end
              PH_ADDR_LO: begin
                load_addr[7:0] = b;
                csum           = csum + b;
                ph             = PH_TYPE;
              end
              PH_TYPE: begin
                rec_kind  = b;
                csum      = csum + b;
                data_left = rec_len;
                wr_ptr    = '0;
                ph        = (rec_len != 8'd0) ? PH_DATA : PH_CHECK;
              end
              PH_DATA: begin
                shadow_store[wr_ptr] = b;
                wr_ptr    = wr_ptr + 8'd1;
                csum      = csum + b;
                data_left = data_left - 8'd1;
                if (data_left == 8'd0) ph = PH_CHECK;
              end
              default: begin
                ph      = PH_IDLE;
                want_ck = 8'h00 - csum;
                if (want_ck != b) begin
                  err = ERR_CHECKSUM;
                end else if (rec_kind == REC_EOF) begin
                  eof_hit = 1'b1;
                end else if (rec_kind != REC_DATA) begin
                  err = ERR_TYPE;
                end else begin
                  tail = load_addr + {8'h00, rec_len};
                  if (tail > top_end) top_end = tail;
                  unread = {1'b0, rec_len};
                  rd_ptr = '0;
                  acc    = 1'b1;
                end
              end
            endcase
          end
        end
      end
    end else if (m == MODE_END) begin
      if (!eof_hit) err = ERR_EARLY;
    end else if (unread != 9'd0) begin
      r.data_valid     = 1'b1;
      r.data_byte      = shadow_store[rd_ptr];
      r.data_address   = load_addr;
      r.last_of_record = (unread == 9'd1);
      rd_ptr           = rd_ptr + 8'd1;
      load_addr        = load_addr + 16'd1;
      unread           = unread - 9'd1;
    end
    r.record_ready    = (unread != 9'd0);
    r.record_accepted = acc;
    r.eof_seen        = eof_hit;
    r.error_code      = err;
    r.end_address     = top_end;
  endtask

  task automatic add_beat(input mode_t m, input logic [7:0] c);
    beat_t t;
    t.m     = m;
    t.c     = c;
    t.fixed = 1'b0;
    t.err   = ERR_NONE;
    stim_q.push_back(t);
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Sender: presents stim_q in order, in bursts with random gaps.
  // valid holds while the beat waits for ready.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.mode      <= MODE_CHAR;
      in_ch.char_code <= 8'h00;
    end else begin
      if (in_ch.valid && in_ch.ready) send_idx++;
      if (in_ch.valid && !in_ch.ready) begin
        // beat still waiting: hold everything
      end else if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (send_idx < stim_q.size()) begin
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= stim_q[send_idx].m;
        in_ch.char_code <= stim_q[send_idx].c;
        if (burst_left > 0) begin
          burst_left--;
        end else if ($urandom_range(0, 99) < 15) begin
          // long stretch with hardly any idling
          burst_left = $urandom_range(100, 300);
          gap_left   = $urandom_range(0, 2);
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left   = $urandom_range(0, 24);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a style that is picked anew whenever its random span runs out:
  // always ready, coin flip, rotating pattern, or mostly stalled.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_style = $urandom_range(0, 3);
      rx_span  = $urandom_range(24, 200);
      rx_pat   = 8'($urandom) | 8'h01;
    end else begin
      rx_span--;
    end
    case (rx_style)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      2: begin
        rx_pat = {rx_pat[6:0], rx_pat[7]};
        out_ch.ready <= rx_pat[0];
      end
      default: out_ch.ready <= ($urandom_range(0, 11) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted input beat, check every result beat
  // against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    result_t guess;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.data_valid      = out_ch.data_valid;
        got.data_byte       = out_ch.data_byte;
        got.data_address    = out_ch.data_address;
        got.last_of_record  = out_ch.last_of_record;
        got.record_ready    = out_ch.record_ready;
        got.record_accepted = out_ch.record_accepted;
        got.eof_seen        = out_ch.eof_seen;
        got.error_code      = out_ch.error_code;
        got.end_address     = out_ch.end_address;
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result beat %0d: %s", beats_out, show(got));
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result beat %0d mismatch\n  expected %s\n  actual   %s",
                       beats_out, show(want), show(got));
          end
        end
        beats_out++;
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_result(mode_t'(in_ch.mode), in_ch.char_code, guess);
        if (stim_q[beats_in].fixed) begin
          want            = '0;
          want.error_code = stim_q[beats_in].err;
        end else begin
          want = guess;
        end
        pending_results.push_back(want);
        beats_in++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long with no beat on either side means a hang.
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main: build stimulus, reset, wait for the last result, report.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n <= 1'b0;
    clear_parser();

    foreach (DIRECTED[i]) stim_q.push_back(DIRECTED[i]);

    // Random part: sessions that open with a restart and carry a few records.
    // Most records are well formed; a flawed one (bad checksum, bad digit,
    // restart or end of input mid-record), a non-data record or a stray
    // character ends the session, since an error would make everything after it ignored.
    begin : gen_random
      int          nrec;
      int          roll;
      int          flaw;
      int          cut_at;
      int          nib_idx;
      bit          closed;
      logic [7:0]  cnt;
      logic [7:0]  kind;
      logic [7:0]  ck;
      logic [7:0]  sum;
      logic [7:0]  c;
      logic [3:0]  nib;
      logic [15:0] addr;
      logic [7:0]  rec[$];
      while (stim_q.size() < $size(DIRECTED) + RANDOM_ITEMS) begin
        add_beat(MODE_RESTART, 8'($urandom));
        nrec   = $urandom_range(1, 6);
        closed = 1'b0;
        for (int r = 0; r < nrec && !closed; r++) begin
          repeat ($urandom_range(0, 2)) add_beat(MODE_CHAR, WS[$urandom_range(0, 5)]);
          roll = $urandom_range(0, 99);
          if (roll < 4) begin
            // stray character between records
            do c = 8'($urandom);
            while (c == CHAR_COLON || c == CHAR_SPACE || (c >= 8'h09 && c <= 8'h0D));
            add_beat(MODE_CHAR, c);
            closed = 1'b1;
          end else begin
            kind = (roll < 82) ? REC_DATA :
                   (roll < 90) ? REC_EOF  : 8'($urandom_range(2, 255));
            // mostly short records, a few long ones up to the full 255
            roll = $urandom_range(0, 99);
            cnt  = (roll < 2)  ? 8'd255 :
                   (roll < 5)  ? 8'($urandom_range(41, 254)) :
                   (roll < 30) ? 8'($urandom_range(9, 40))   : 8'($urandom_range(0, 8));
            // addresses near the top exercise the 16-bit wrap
            roll = $urandom_range(0, 99);
            addr = (roll < 20) ? 16'hFFFF - 16'($urandom_range(0, 48)) :
                   (roll < 30) ? 16'($urandom_range(0, 16)) : 16'($urandom);
            roll = $urandom_range(0, 99);
            flaw = (roll < 6)  ? 1 :   // bad checksum
                   (roll < 10) ? 2 :   // non-hex character
                   (roll < 12) ? 3 :   // restart mid-record
                   (roll < 14) ? 4 :   // end of input mid-record
                   (roll < 22) ? 5 :   // read request mid-record
                                 0;
            rec.delete();
            rec.push_back(cnt);
            rec.push_back(addr[15:8]);
            rec.push_back(addr[7:0]);
            rec.push_back(kind);
            repeat (cnt) rec.push_back(8'($urandom));
            sum = 8'h00;
            foreach (rec[i]) sum = sum + rec[i];
            ck = 8'h00 - sum;
            if (flaw == 1) ck = ck ^ 8'($urandom_range(1, 255));
            rec.push_back(ck);
            cut_at = $urandom_range(0, 2 * rec.size() - 1);
            add_beat(MODE_CHAR, CHAR_COLON);
            for (nib_idx = 0; nib_idx < 2 * rec.size(); nib_idx++) begin
              if (flaw >= 2 && nib_idx == cut_at) begin
                case (flaw)
                  2: begin
                    do c = 8'($urandom);
                    while (digit_val(c) >= 0);
                    add_beat(MODE_CHAR, c);
                  end
                  3: add_beat(MODE_RESTART, 8'($urandom));
                  4: add_beat(MODE_END, 8'($urandom));
                  default: add_beat(MODE_READ, 8'($urandom));
                endcase
                if (flaw != 5) break;
              end
              nib = nib_idx[0] ? rec[nib_idx / 2][3:0] : rec[nib_idx / 2][7:4];
              c   = (nib < 4'd10) ? 8'h30 + nib :
                    (($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + nib - 8'd10;
              add_beat(MODE_CHAR, c);
            end
            if ((flaw >= 1 && flaw <= 4) || kind != REC_DATA) begin
              closed = 1'b1;
            end else begin
              // drain some, all or more than all of the record
              repeat ($urandom_range(0, cnt + 2)) add_beat(MODE_READ, 8'($urandom));
            end
          end
        end
        // Session tail: end of input (ignored after end-of-file), a few
        // random characters, a few reads, or nothing.
        case ($urandom_range(0, 3))
          0: add_beat(MODE_END, 8'($urandom));
          1: repeat ($urandom_range(1, 3)) add_beat(MODE_CHAR, 8'($urandom));
          2: repeat ($urandom_range(1, 3)) add_beat(MODE_READ, 8'($urandom));
          default: ;
        endcase
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_in < stim_q.size()) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> intel_hex_record_parser.f
sv/ihex_pkg.sv
sv/ihex_in_if.sv
sv/ihex_out_if.sv
sv/ihex_store.sv
sv/ihex_parse_core.sv
sv/ihex_out_fifo.sv
sv/intel_hex_record_parser.sv
tb/tb_top.sv
